// ===== design/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion wrappers for the countdown timer checkers.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks a property at every rising clock edge outside of reset.
`define ASSERT_CLKD(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Checks that a condition in one cycle implies a consequence in the next.
`define ASSERT_NEXT(label, clk, rst_n, cond, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (cons)) \
        else $error(msg);

`endif

// ===== design/hsct_pkg.sv =====
// ----------------------------------------------------------------------------
// hsct_pkg
// Types and constants of the hour-step countdown timer.
// ----------------------------------------------------------------------------
package hsct_pkg;

    localparam logic [2:0] REQ_TICK  = 3'd0;
    localparam logic [2:0] REQ_KEY   = 3'd1;
    localparam logic [2:0] REQ_SET   = 3'd2;
    localparam logic [2:0] REQ_STOP  = 3'd3;
    localparam logic [2:0] REQ_ALIGN = 3'd4;

    localparam logic [2:0] MODE_OFF = 3'd0;
    localparam logic [2:0] MODE_1H  = 3'd1;
    localparam logic [2:0] MODE_2H  = 3'd2;
    localparam logic [2:0] MODE_4H  = 3'd3;
    localparam logic [2:0] MODE_6H  = 3'd4;

    localparam logic [1:0] ION_NORMAL   = 2'd0;
    localparam logic [1:0] ION_SHOWER   = 2'd1;
    localparam logic [1:0] ION_CLOTHING = 2'd2;

    localparam logic [1:0] ACT_NONE   = 2'd0;
    localparam logic [1:0] ACT_POWER  = 2'd1;
    localparam logic [1:0] ACT_REINIT = 2'd2;

    localparam logic [1:0] BEEP_NONE   = 2'd0;
    localparam logic [1:0] BEEP_SINGLE = 2'd1;
    localparam logic [1:0] BEEP_DOUBLE = 2'd2;

    localparam logic [6:0] FINE_RELOAD = 7'd100;
    localparam logic [6:0] STEP_FAST   = 7'd20;
    localparam logic [6:0] STEP_SHOWER = 7'd10;

    localparam logic [7:0] UNITS_1H = 8'd36;
    localparam logic [7:0] UNITS_2H = 8'd72;
    localparam logic [7:0] UNITS_4H = 8'd144;
    localparam logic [7:0] UNITS_6H = 8'd216;

    typedef struct packed {
        logic [2:0] req_type;
        logic [2:0] set_mode;
        logic [1:0] ion_mode;
    } in_t;

    typedef struct packed {
        logic [2:0] timer_mode;
        logic [7:0] coarse_left;
        logic       time_reached;
        logic [1:0] expiry_action;
        logic       save_mode;
        logic [1:0] beep_kind;
    } out_t;

    typedef struct packed {
        logic [6:0] fine_count;
        logic [7:0] coarse_count;
        logic [2:0] mode_now;
    } state_t;

    localparam state_t STATE_RESET = '{fine_count: FINE_RELOAD, coarse_count: 8'd0,
                                       mode_now: MODE_OFF};

    function automatic logic [7:0] preset_units(input logic [2:0] mode);
        logic [7:0] units;
        unique case (mode)
            MODE_1H: units = UNITS_1H;
            MODE_2H: units = UNITS_2H;
            MODE_4H: units = UNITS_4H;
            MODE_6H: units = UNITS_6H;
            default: units = 8'd0;
        endcase
        return units;
    endfunction

    function automatic logic [6:0] round_down_fast(input logic [6:0] fine);
        logic [6:0] r;
        priority if (fine >= 7'd120) r = 7'd120;
        else if (fine >= 7'd100) r = 7'd100;
        else if (fine >= 7'd80) r = 7'd80;
        else if (fine >= 7'd60) r = 7'd60;
        else if (fine >= 7'd40) r = 7'd40;
        else if (fine >= 7'd20) r = 7'd20;
        else r = 7'd0;
        return r;
    endfunction

endpackage

// ===== design/hsct_core.sv =====
// ----------------------------------------------------------------------------
// hsct_core
// Next-state and result logic for one timer request.
// ----------------------------------------------------------------------------
module hsct_core (
    input  hsct_pkg::state_t st,
    input  hsct_pkg::in_t    item,
    input  logic             speed_up,
    output hsct_pkg::state_t st_next,
    output hsct_pkg::out_t   result
);

    logic [6:0] step;
    logic [6:0] fine_sub;
    logic [6:0] fine_round;
    logic [7:0] coarse_dec;
    logic [3:0] mode_inc;
    logic       save_ok;
    logic       reached;
    logic [1:0] action;
    logic       save;
    logic [1:0] beep;

    assign step = !speed_up ? 7'd1 :
                  (item.ion_mode == hsct_pkg::ION_SHOWER) ? hsct_pkg::STEP_SHOWER
                                                          : hsct_pkg::STEP_FAST;
    assign fine_sub   = (st.fine_count > step) ? (st.fine_count - step) : 7'd0;
    assign fine_round = hsct_pkg::round_down_fast(st.fine_count);
    assign coarse_dec = st.coarse_count - 8'd1;
    assign mode_inc   = {1'b0, st.mode_now} + 4'd1;
    assign save_ok    = (item.ion_mode != hsct_pkg::ION_CLOTHING);

    always_comb
    begin
        st_next = st;
        reached = 1'b0;
        action  = hsct_pkg::ACT_NONE;
        save    = 1'b0;
        beep    = hsct_pkg::BEEP_NONE;
        unique case (item.req_type)
            hsct_pkg::REQ_TICK:
            begin
                if (st.fine_count != 7'd0)
                begin
                    if (fine_sub != 7'd0)
                    begin
                        st_next.fine_count = fine_sub;
                    end
                    else
                    begin
                        st_next.fine_count = hsct_pkg::FINE_RELOAD;
                        if (st.coarse_count != 8'd0)
                        begin
                            st_next.coarse_count = coarse_dec;
                            priority if (coarse_dec == hsct_pkg::UNITS_1H)
                            begin
                                st_next.mode_now = hsct_pkg::MODE_1H;
                                save = save_ok;
                            end
                            else if (coarse_dec == hsct_pkg::UNITS_2H)
                            begin
                                st_next.mode_now = hsct_pkg::MODE_2H;
                                save = save_ok;
                            end
                            else if (coarse_dec == hsct_pkg::UNITS_4H)
                            begin
                                st_next.mode_now = hsct_pkg::MODE_4H;
                                save = save_ok;
                            end
                            else if (coarse_dec == 8'd0)
                            begin
                                st_next.mode_now = hsct_pkg::MODE_OFF;
                                reached = 1'b1;
                                action = (item.ion_mode == hsct_pkg::ION_SHOWER) ?
                                         hsct_pkg::ACT_REINIT : hsct_pkg::ACT_POWER;
                                save = save_ok;
                            end
                            else
                            begin
                                save = 1'b0;
                            end
                        end
                        else
                        begin
                            save = save_ok;
                        end
                    end
                end
            end
            hsct_pkg::REQ_KEY:
            begin
                if (mode_inc > {1'b0, hsct_pkg::MODE_6H})
                begin
                    st_next.mode_now = hsct_pkg::MODE_OFF;
                    st_next.coarse_count = 8'd0;
                    beep = hsct_pkg::BEEP_DOUBLE;
                end
                else
                begin
                    st_next.mode_now = mode_inc[2:0];
                    st_next.coarse_count = hsct_pkg::preset_units(mode_inc[2:0]);
                    beep = hsct_pkg::BEEP_SINGLE;
                end
                st_next.fine_count = hsct_pkg::FINE_RELOAD;
                save = 1'b1;
            end
            hsct_pkg::REQ_SET:
            begin
                if (item.set_mode <= hsct_pkg::MODE_6H)
                begin
                    st_next.coarse_count = hsct_pkg::preset_units(item.set_mode);
                    if (item.set_mode != hsct_pkg::MODE_OFF &&
                        item.ion_mode != hsct_pkg::ION_SHOWER)
                    begin
                        st_next.mode_now = item.set_mode;
                    end
                    st_next.fine_count = hsct_pkg::FINE_RELOAD;
                    save = (item.ion_mode == hsct_pkg::ION_NORMAL);
                end
            end
            hsct_pkg::REQ_STOP:
            begin
                st_next.mode_now = hsct_pkg::MODE_OFF;
                st_next.coarse_count = 8'd0;
                st_next.fine_count = hsct_pkg::FINE_RELOAD;
                save = 1'b1;
            end
            hsct_pkg::REQ_ALIGN:
            begin
                if (st.coarse_count != 8'd0)
                begin
                    if (fine_round == 7'd0)
                    begin
                        st_next.fine_count = hsct_pkg::FINE_RELOAD;
                        st_next.coarse_count = coarse_dec;
                    end
                    else
                    begin
                        st_next.fine_count = fine_round;
                    end
                end
            end
            default:
            begin
                st_next = st;
            end
        endcase
    end

    always_comb
    begin
        result.timer_mode    = st_next.mode_now;
        result.coarse_left   = st_next.coarse_count;
        result.time_reached  = reached;
        result.expiry_action = action;
        result.save_mode     = save;
        result.beep_kind     = beep;
    end

endmodule

// ===== design/hour_step_countdown_timer.sv =====
// ----------------------------------------------------------------------------
// hour_step_countdown_timer
// Countdown timer with hour presets, driven by one request per item.
//
//   Channel  | Handshake                 | Payload
//   ---------+---------------------------+--------------------------
//   in       | in_valid / in_ready       | in_data  (hsct_pkg::in_t)
//   out      | out_valid / out_ready     | out_data (hsct_pkg::out_t)
//   cfg      | cfg_valid / cfg_ready     | cfg_data (speed-up enable)
//
// One request is taken every cycle unless the result stalls; a request moves from
// the input register into the result register, where its result becomes valid.
// Reset loads the reload value into the sub-counter and turns the timer off.
// A stalled result holds the input register; in_ready drops only when both
// registers are full and out_ready is low.
// ----------------------------------------------------------------------------
module hour_step_countdown_timer (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_ready,
    input  hsct_pkg::in_t  in_data,
    output logic           out_valid,
    input  logic           out_ready,
    output hsct_pkg::out_t out_data,
    input  logic           cfg_valid,
    output logic           cfg_ready,
    input  logic           cfg_data
);

    logic             item_valid_reg;
    hsct_pkg::in_t    item_reg;
    hsct_pkg::state_t state_reg;
    hsct_pkg::state_t state_next;
    logic             out_valid_reg;
    hsct_pkg::out_t   out_data_reg;
    hsct_pkg::out_t   result;
    logic             speed_up_reg;
    logic             advance;

    assign advance   = item_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready  = !item_valid_reg || advance;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;
    assign cfg_ready = 1'b1;

    hsct_core u_core (
        .st       (state_reg),
        .item     (item_reg),
        .speed_up (speed_up_reg),
        .st_next  (state_next),
        .result   (result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
            state_reg      <= hsct_pkg::STATE_RESET;
            speed_up_reg   <= 1'b0;
        end
        else
        begin
            if (in_ready)
            begin
                item_valid_reg <= in_valid;
            end
            if (advance)
            begin
                out_valid_reg <= 1'b1;
                state_reg     <= state_next;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
            if (cfg_valid)
            begin
                speed_up_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            item_reg <= in_data;
        end
        if (advance)
        begin
            out_data_reg <= result;
        end
    end

endmodule

// ===== design/hsct_checker.sv =====
// ----------------------------------------------------------------------------
// hsct_checker
// Port-level checks on the results of the countdown timer.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module hsct_checker (
    input logic           clk,
    input logic           rst_n,
    input logic           out_valid,
    input logic           out_ready,
    input hsct_pkg::out_t out_data
);

    `ASSERT_CLKD(a_coarse_range, clk, rst_n,
        !out_valid || out_data.coarse_left <= hsct_pkg::UNITS_6H,
        "coarse count above six hours")

    `ASSERT_CLKD(a_reached_off, clk, rst_n,
        !(out_valid && out_data.time_reached) ||
        (out_data.timer_mode == hsct_pkg::MODE_OFF && out_data.coarse_left == 8'd0),
        "expiry with time left")

    `ASSERT_CLKD(a_action_reached, clk, rst_n,
        !out_valid ||
        (out_data.time_reached == (out_data.expiry_action != hsct_pkg::ACT_NONE)),
        "expiry action without expiry")

    `ASSERT_CLKD(a_double_beep, clk, rst_n,
        !(out_valid && out_data.beep_kind == hsct_pkg::BEEP_DOUBLE) ||
        (out_data.timer_mode == hsct_pkg::MODE_OFF && out_data.coarse_left == 8'd0 &&
         out_data.save_mode),
        "double beep while running")

    `ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready,
        out_valid && $stable(out_data), "stalled result changed")

endmodule

bind hour_step_countdown_timer hsct_checker u_hsct_checker (.*);
